>>> rtl/core/ddm_pkg.sv
// Shared types and constants for the decimal digit multiplier.
package ddm_pkg;

  localparam int MaxDigitsDef = 16;
  localparam int MaxOut       = 32;

  localparam logic [1:0] CMD_LOAD_A   = 2'd0;
  localparam logic [1:0] CMD_LOAD_B   = 2'd1;
  localparam logic [1:0] CMD_MULTIPLY = 2'd2;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] digit;
  } ddm_in_t;

  typedef struct packed {
    logic [3:0] product_digit;
    logic [4:0] digit_position;
    logic       last;
    logic       overflow;
  } ddm_out_t;

endpackage

>>> rtl/core/decimal_digit_multiplier_core.sv
// Schoolbook decimal multiplier: operand digit stores, column sequencer, carry pass, emitter.
// Load: taken in S_IDLE; multiply: per column S_COL, S_TERM per term, S_DR1, S_DR2, S_DIV1,
//   S_DIV2 (S_COL to S_DIV1 with no terms) on the shared 4x4 multiplier and divide-by-ten
//   unit, then S_EMRD, S_EMIT per digit, held by output stalls; input stalls until the last.
// Synchronous active-low reset clears counts, overflow flag and sequencer; digit stores
//   hold whatever they held and are read only where written.
module decimal_digit_multiplier_core #(
  parameter int MAX_DIGITS = ddm_pkg::MaxDigitsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ddm_pkg::ddm_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ddm_pkg::ddm_out_t out_data
);

  localparam int Cols = 2 * MAX_DIGITS;
  localparam int IW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int KW   = $clog2(Cols);
  localparam int W    = KW + 1;
  localparam int CNW  = $clog2(MAX_DIGITS + 1);
  localparam int CW   = $clog2(MAX_DIGITS * 81 * 2);

  typedef enum logic [3:0] {
    S_IDLE, S_COL, S_TERM, S_DR1, S_DR2, S_DIV1, S_DIV2, S_EMRD, S_EMIT
  } state_t;

  state_t           state_r;
  logic [CNW-1:0]   cnt_a_r, cnt_b_r;
  logic             ovf_r;
  logic [KW-1:0]    k_r;
  logic [KW-1:0]    top_r;
  logic [W-1:0]     i_r, ihi_r;
  logic [CW-1:0]    carry_r, tot_r, q_r, acc_r;
  logic [4:0]       pos_r;
  logic             out_valid_r;

  logic [3:0]       a_mem [MAX_DIGITS];
  logic [3:0]       b_mem [MAX_DIGITS];
  logic [3:0]       dig_mem [Cols];
  logic [3:0]       a_rd_r, b_rd_r, dig_rd_r;
  logic             rv_r, pv_r;
  logic [7:0]       prod_r;

  logic             in_acc, a_we, b_we, dig_we;
  logic [3:0]       load_digit;
  logic [W-1:0]     k_w, ca_w, cb_w, ilo, ihi, j_w;
  logic             has_terms;
  logic [CW-1:0]    tot, q_calc, r_raw, r_fix, q_fix;
  logic [15:0]      tot16;
  logic [31:0]      qmul;
  logic             top_big;
  logic [4:0]       last_pos;

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign load_digit = (in_data.digit > ddm_pkg::DIGIT_MAX) ? ddm_pkg::DIGIT_MAX : in_data.digit;
  assign a_we = in_acc && (in_data.command == ddm_pkg::CMD_LOAD_A) &&
                (cnt_a_r < CNW'(MAX_DIGITS));
  assign b_we = in_acc && (in_data.command == ddm_pkg::CMD_LOAD_B) &&
                (cnt_b_r < CNW'(MAX_DIGITS));

  assign k_w  = W'(k_r);
  assign ca_w = W'(cnt_a_r);
  assign cb_w = W'(cnt_b_r);
  assign ilo  = (k_w >= cb_w) ? (k_w - cb_w + W'(1)) : '0;
  assign ihi  = (k_w < ca_w) ? k_w : (ca_w - W'(1));
  assign has_terms = (cnt_a_r != '0) && (cnt_b_r != '0) && (ilo <= ihi);
  assign j_w  = k_w - i_r;

  assign tot    = acc_r + carry_r;
  assign tot16  = 16'(tot);
  assign qmul   = {16'd0, tot16} * 32'd52429;
  assign q_calc = CW'(qmul >> 19);
  assign r_raw  = tot_r - (CW'({q_r, 3'b000}) + CW'({q_r, 1'b0}));
  assign r_fix  = (r_raw >= CW'(10)) ? (r_raw - CW'(10)) : r_raw;
  assign q_fix  = (r_raw >= CW'(10)) ? (q_r + CW'(1)) : q_r;
  assign dig_we = (state_r == S_DIV2);

  assign top_big  = (top_r >> 5) != '0;
  assign last_pos = top_big ? 5'd31 : 5'(top_r);

  assign out_valid               = out_valid_r;
  assign out_data.product_digit  = dig_rd_r;
  assign out_data.digit_position = pos_r;
  assign out_data.last           = (pos_r == last_pos);
  assign out_data.overflow       = ovf_r | top_big;

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[cnt_a_r[IW-1:0]] <= load_digit;
    end
    if (b_we) begin
      b_mem[cnt_b_r[IW-1:0]] <= load_digit;
    end
    if (dig_we) begin
      dig_mem[k_r] <= r_fix[3:0];
    end
    a_rd_r   <= a_mem[i_r[IW-1:0]];
    b_rd_r   <= b_mem[j_w[IW-1:0]];
    dig_rd_r <= dig_mem[KW'(pos_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      rv_r <= (state_r == S_TERM);
      pv_r <= rv_r;
    end
    prod_r <= a_rd_r * b_rd_r;
    if (state_r == S_COL) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + CW'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      top_r       <= '0;
      pos_r       <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            priority if (in_data.command == ddm_pkg::CMD_LOAD_A) begin
              if (a_we) cnt_a_r <= cnt_a_r + CNW'(1);
              else ovf_r <= 1'b1;
            end else if (in_data.command == ddm_pkg::CMD_LOAD_B) begin
              if (b_we) cnt_b_r <= cnt_b_r + CNW'(1);
              else ovf_r <= 1'b1;
            end else if (in_data.command == ddm_pkg::CMD_MULTIPLY) begin
              k_r     <= '0;
              top_r   <= '0;
              carry_r <= '0;
              state_r <= S_COL;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_COL: begin
          if (has_terms) begin
            i_r     <= ilo;
            ihi_r   <= ihi;
            state_r <= S_TERM;
          end else begin
            state_r <= S_DIV1;
          end
        end
        S_TERM: begin
          if (i_r == ihi_r) begin
            state_r <= S_DR1;
          end else begin
            i_r <= i_r + W'(1);
          end
        end
        S_DR1: state_r <= S_DR2;
        S_DR2: state_r <= S_DIV1;
        S_DIV1: begin
          tot_r   <= tot;
          q_r     <= q_calc;
          state_r <= S_DIV2;
        end
        S_DIV2: begin
          carry_r <= q_fix;
          if (r_fix != '0) top_r <= k_r;
          if (k_r == KW'(Cols - 1)) begin
            pos_r   <= '0;
            state_r <= S_EMRD;
          end else begin
            k_r     <= k_r + KW'(1);
            state_r <= S_COL;
          end
        end
        S_EMRD: begin
          out_valid_r <= 1'b1;
          state_r     <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (pos_r == last_pos) begin
              cnt_a_r <= '0;
              cnt_b_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              pos_r   <= pos_r + 5'd1;
              state_r <= S_EMRD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_EMIT))
    else $error("result valid outside emit phase");
  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");
  a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.product_digit <= ddm_pkg::DIGIT_MAX))
    else $error("product digit above nine");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last) |=>
      (cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r && state_r == S_IDLE))
    else $error("operands not cleared after product");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNW'(MAX_DIGITS)) && (cnt_b_r <= CNW'(MAX_DIGITS)))
    else $error("operand count beyond capacity");
`endif

endmodule
